### hw/rtl/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache.
// Holds the request and response beat structs, the cell control struct
// and the operation codes. Depends on nothing.
package lkv_pkg;

    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 64;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;
    localparam int OCC_W   = 5;

    localparam logic [FUNC_W-1:0] FUNC_STORE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] value_out;
        logic [OCC_W-1:0]   occupancy;
    } rsp_t;

    // One-cycle commands broadcast to every cell.
    typedef struct packed {
        logic search; // compare the held key against the request key
        logic clear;  // drop every entry
        logic insert; // every cell takes its left neighbour's entry
        logic touch;  // cells up to the hit take their left neighbour's entry
    } cell_ctl_t;

endpackage

### hw/rtl/lkv_cell.sv
// One recency-ordered slot of the LRU cache chain.
// Holds a key, a value, a valid flag and a registered match flag.
// Depends on lkv_pkg for the cell control struct.
module lkv_cell #(
    parameter int IDX        = 0,
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32,
    localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lkv_pkg::cell_ctl_t    ctl,
    input  logic [KEY_BITS-1:0]   cmp_key,
    input  logic [CNT_W-1:0]      cap,
    // entry of the more recent neighbour (or the new head for the first cell)
    input  logic [KEY_BITS-1:0]   left_key,
    input  logic [VALUE_BITS-1:0] left_value,
    input  logic                  left_valid,
    // chains running from the least recent end towards the head
    input  logic                  hit_in,
    input  logic [VALUE_BITS-1:0] hit_value_in,
    output logic                  hit_out,
    output logic [VALUE_BITS-1:0] hit_value_out,
    output logic [KEY_BITS-1:0]   key,
    output logic [VALUE_BITS-1:0] value,
    output logic                  valid
);
    import lkv_pkg::*;

    logic [KEY_BITS-1:0]   key_reg,   key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  valid_reg, valid_next;
    logic                  match_reg, match_next;
    logic                  load;
    logic                  in_cap;

    // Set when the hit lies in this cell or further from the head.
    assign hit_out       = hit_in | match_reg;
    assign hit_value_out = hit_value_in | (match_reg ? value_reg : '0);
    assign in_cap        = CNT_W'(IDX) < cap;
    assign load          = ctl.insert | (ctl.touch & hit_out);

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        valid_next = valid_reg;
        match_next = match_reg;
        if (ctl.search)
        begin
            match_next = valid_reg && (key_reg == cmp_key);
        end
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (load)
        begin
            key_next   = left_key;
            value_next = left_value;
            valid_next = ctl.insert ? (left_valid & in_cap) : left_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign valid = valid_reg;

endmodule

### hw/rtl/lru_key_value_cache_top.sv
// Top level of the fully associative LRU key/value cache.
// Instantiates a chain of lkv_cell slots ordered by recency; depends on lkv_pkg.
//
//  Channel   Signals                        Direction  Beat contents
//  -------   -----------------------------  ---------  -----------------------------
//  req       req_valid, req_ready, req      in         func, key, value_in
//  rsp       rsp_valid, rsp_ready, rsp      out        ok, value_out, occupancy
//  cfg       cfg_we, cfg_wdata              in         capacity_limit, no handshake
//
// Each request beat passes a search state, which compares every slot against the key
// and registers the match flags, then an update state, which shifts the chain and loads
// the response register. A new request beat is taken only while idle or as the current
// one commits. The response register lets a finished result wait while the next request
// is searched; the update state stalls only while that register is still full.
// After reset every slot is empty and the capacity is 16; no clearing pass is needed.
module lru_key_value_cache_top #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  lkv_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output lkv_pkg::rsp_t               rsp,
    input  logic                        cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]   cfg_wdata
);
    import lkv_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0]       state_reg, state_next;
    req_t             req_reg;
    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic                  req_fire;
    logic                  commit;
    logic [CNT_W-1:0]      cap_eff;
    logic [KEY_BITS-1:0]   req_key;
    logic [VALUE_BITS-1:0] req_value;
    logic                  store_ok;
    logic                  hit;
    logic [VALUE_BITS-1:0] hit_value;
    logic [VALUE_BITS-1:0] head_value;
    cell_ctl_t             ctl;

    // Chain wiring: index ENTRIES is the far end of the hit chains, and the
    // slot arrays carry each cell's entry to its less recent neighbour.
    logic                  hit_chain   [ENTRIES+1];
    logic [VALUE_BITS-1:0] value_chain [ENTRIES+1];
    logic [KEY_BITS-1:0]   slot_key    [ENTRIES+1];
    logic [VALUE_BITS-1:0] slot_value  [ENTRIES+1];
    logic                  slot_valid  [ENTRIES+1];

    assign req_key   = req_reg.key[KEY_BITS-1:0];
    assign req_value = VALUE_BITS'(req_reg.value_in);
    assign store_ok  = (req_key != '0) && (req_value != '0);

    // A capacity of zero behaves as one, and anything above the slot count saturates.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (32'(cap_reg) > 32'(ENTRIES))
        begin
            cap_eff = CNT_W'(ENTRIES);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign commit    = (state_reg == S_UPDATE) && (!rsp_valid_reg || rsp_ready);
    assign req_ready = (state_reg == S_IDLE) || commit;
    assign req_fire  = req_valid && req_ready;

    assign hit       = hit_chain[0];
    assign hit_value = value_chain[0];

    // The head of the chain receives the entry that becomes most recent.
    assign head_value     = (req_reg.func == FUNC_STORE) ? req_value : hit_value;
    assign slot_key[0]    = req_key;
    assign slot_value[0]  = head_value;
    assign slot_valid[0]  = 1'b1;
    assign hit_chain[ENTRIES]   = 1'b0;
    assign value_chain[ENTRIES] = '0;

    // Decode the registered request into chain commands and the response beat.
    always_comb
    begin
        ctl             = '0;
        ctl.search      = (state_reg == S_SEARCH);
        count_next      = count_reg;
        rsp_next.ok        = 1'b0;
        rsp_next.value_out = '0;
        case (req_reg.func)
            FUNC_STORE:
            begin
                if (store_ok)
                begin
                    rsp_next.ok = 1'b1;
                    if (hit)
                    begin
                        ctl.touch = commit;
                    end
                    else
                    begin
                        // Old entries move one place back; those past the capacity drop.
                        ctl.insert = commit;
                        count_next = (count_reg >= cap_eff) ? cap_eff
                                                            : count_reg + 1'b1;
                    end
                end
            end
            FUNC_LOOKUP:
            begin
                rsp_next.ok        = hit;
                rsp_next.value_out = VALUE_W'(hit_value);
                ctl.touch          = commit & hit;
            end
            FUNC_PEEK:
            begin
                rsp_next.ok        = hit;
                rsp_next.value_out = VALUE_W'(hit_value);
            end
            FUNC_CLEAR:
            begin
                rsp_next.ok = 1'b1;
                ctl.clear   = commit;
                count_next  = '0;
            end
            default:
            begin
                rsp_next.ok = 1'b0;
            end
        endcase
        rsp_next.occupancy = OCC_W'(count_next);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (commit)
                begin
                    state_next = req_fire ? S_SEARCH : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_W'(16);
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req;
        end
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Slot 0 is the most recent entry; valid slots always sit together at the head.
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lkv_cell #(
            .IDX        (i),
            .ENTRIES    (ENTRIES),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ctl),
            .cmp_key       (req_key),
            .cap           (cap_eff),
            .left_key      (slot_key[i]),
            .left_value    (slot_value[i]),
            .left_valid    (slot_valid[i]),
            .hit_in        (hit_chain[i+1]),
            .hit_value_in  (value_chain[i+1]),
            .hit_out       (hit_chain[i]),
            .hit_value_out (value_chain[i]),
            .key           (slot_key[i+1]),
            .value         (slot_value[i+1]),
            .valid         (slot_valid[i+1])
        );
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### sim/testbench.sv
// Self-checking testbench for the LRU key/value cache top level.
// Holds its own LRU predictor, a table of directed beats and randomised traffic with
// idling and back-pressure on both channels; depends on lkv_pkg and lru_key_value_cache_top.
module testbench;
    import lkv_pkg::*;

    localparam int SLOTS       = 16;
    localparam int POOL        = 24;   // a few more keys than slots, so that entries get evicted
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 94;
    localparam int HOLD_AT     = 330;  // request beats taken before the long response hold-off
    localparam int HOLD_CYCLES = 90;

    typedef enum logic { ROW_BEAT, ROW_CAPACITY } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        req_t              beat;
        bit                typed;  // expected response given in the row itself
        rsp_t              want;
        logic [CAP_W-1:0]  cap;
    } script_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    req_t              req;
    logic              rsp_valid;
    logic              rsp_ready;
    rsp_t              rsp;
    logic              cfg_we;
    logic [CAP_W-1:0]  cfg_wdata;

    // Predicted contents of the cache. A slot's key and value are only read while it is live.
    logic [KEY_W-1:0]   slot_key   [SLOTS];
    logic [VALUE_W-1:0] slot_value [SLOTS];
    bit                 slot_live  [SLOTS];
    int                 slot_rank  [SLOTS];  // 0 is the most recently used
    int                 live_count;
    logic [CAP_W-1:0]   capacity;

    rsp_t              pending_rsp[$];   // responses still owed by the block, oldest first
    script_row_t       script[$];
    logic [KEY_W-1:0]  key_pool [POOL];
    int                beats_taken;
    int                error_count;
    bit                steady;     // no idling on either side
    bit                holding;    // the response side is holding off
    bit                hold_done;

    lru_key_value_cache_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // Reset is applied once and released on a rising edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // A generous ceiling on the whole run; a healthy run finishes in a small fraction of it.
    initial
    begin
        #200000;
        $display("Verification failed");
        $finish;
    end

    // Moves slot s to the front of the recency order. Every live slot that was more recent
    // than it slides back by one place.
    function automatic void make_most_recent(int s);
        int i;
        for (i = 0; i < SLOTS; i++)
        begin
            if (slot_live[i] && slot_rank[i] < slot_rank[s])
                slot_rank[i]++;
        end
        slot_rank[s] = 0;
    endfunction

    // Applies one request beat to the predicted cache and returns the response it owes.
    function automatic rsp_t cache_outcome(req_t r);
        rsp_t o;
        int   hit;
        int   cap;
        int   i;
        o   = '0;
        hit = -1;
        for (i = SLOTS - 1; i >= 0; i--)
        begin
            if (slot_live[i] && slot_key[i] == r.key)
                hit = i;
        end
        case (r.func)
            FUNC_STORE:
            begin
                // An empty key or an empty value is refused and leaves everything alone.
                if (r.key != '0 && r.value_in != '0)
                begin
                    if (hit >= 0)
                    begin
                        slot_value[hit] = r.value_in;
                        make_most_recent(hit);
                    end
                    else
                    begin
                        // Zero capacity behaves as one; anything above the slot count saturates.
                        cap = (capacity == '0) ? 1 : (capacity > SLOTS) ? SLOTS : int'(capacity);
                        // The newcomer takes the front, so every old entry ages by one and
                        // whatever then falls outside the capacity is dropped. This is also
                        // where any excess from an earlier lowering of the capacity goes.
                        for (i = 0; i < SLOTS; i++)
                        begin
                            if (slot_live[i])
                            begin
                                if (slot_rank[i] + 1 >= cap)
                                begin
                                    slot_live[i] = 1'b0;
                                    slot_rank[i] = 0;
                                    live_count--;
                                end
                                else
                                    slot_rank[i]++;
                            end
                        end
                        for (i = SLOTS - 1; i >= 0; i--)
                        begin
                            if (!slot_live[i])
                                hit = i;
                        end
                        slot_key[hit]   = r.key;
                        slot_value[hit] = r.value_in;
                        slot_live[hit]  = 1'b1;
                        slot_rank[hit]  = 0;
                        live_count++;
                    end
                    o.ok = 1'b1;
                end
            end
            FUNC_LOOKUP, FUNC_PEEK:
            begin
                if (hit >= 0)
                begin
                    o.ok        = 1'b1;
                    o.value_out = slot_value[hit];
                    // Only a lookup refreshes the entry; a peek leaves the order as it is.
                    if (r.func == FUNC_LOOKUP)
                        make_most_recent(hit);
                end
            end
            default:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    slot_live[i] = 1'b0;
                    slot_rank[i] = 0;
                end
                live_count = 0;
                o.ok       = 1'b1;
            end
        endcase
        o.occupancy = OCC_W'(live_count);
        return o;
    endfunction

    // Mostly keys from the pool so that stores, lookups and peeks keep meeting each other;
    // the rest are empty keys and wholly random keys that almost never hit.
    function automatic req_t random_beat();
        req_t r;
        int   roll;
        roll = $urandom_range(99);
        r.func = (roll < 45) ? FUNC_STORE : (roll < 72) ? FUNC_LOOKUP :
                 (roll < 97) ? FUNC_PEEK : FUNC_CLEAR;
        roll = $urandom_range(99);
        if (roll < 82)
            r.key = key_pool[$urandom_range(POOL - 1)];
        else if (roll < 91)
            r.key = '0;
        else
            r.key = {$urandom, $urandom};
        r.value_in = ($urandom_range(99) < 8) ? '0 : VALUE_W'($urandom);
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch in %s: got %0h, expected %0h, after %0d request beats",
                 what, got, want, beats_taken);
        error_count++;
    endtask

    task automatic add_beat(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                            logic [VALUE_W-1:0] v, bit typed = 1'b0, rsp_t want = '0);
        script_row_t row;
        row.kind           = ROW_BEAT;
        row.beat.func      = f;
        row.beat.key       = k;
        row.beat.value_in  = v;
        row.typed          = typed;
        row.want           = want;
        row.cap            = '0;
        script.insert(script.size(), row);
    endtask

    task automatic add_capacity(logic [CAP_W-1:0] c);
        script_row_t row;
        row.kind  = ROW_CAPACITY;
        row.beat  = '0;
        row.typed = 1'b0;
        row.want  = '0;
        row.cap   = c;
        script.insert(script.size(), row);
    endtask

    // Offers one request beat, after a random gap unless idling is switched off, and waits
    // for it to be taken. The expected response is queued at the edge that takes the beat.
    task automatic send_beat(req_t r, bit typed, rsp_t want);
        rsp_t predicted;
        if (!steady && !holding)
        begin
            while ($urandom_range(99) < 37)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        beats_taken++;
        predicted = cache_outcome(r);
        pending_rsp.insert(pending_rsp.size(), typed ? want : predicted);
    endtask

    // Stops offering beats until every owed response has come back, then lets the
    // block's pipeline run dry.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The capacity register is only written with the block idle.
    task automatic write_capacity(logic [CAP_W-1:0] c);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we   <= 1'b0;
        capacity = c;
    endtask

    // Response side: random back-pressure, none while traffic is steady, and one long
    // hold-off part-way through so that the response register fills and the request side
    // stalls while beats are still on offer.
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && beats_taken >= HOLD_AT)
            begin
                hold_done = 1'b1;
                holding   <= 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding <= 1'b0;
            end
            rsp_ready <= steady || ($urandom_range(99) >= 37);
        end
    end

    // Every response beat is checked field by field against the oldest owed response.
    always @(posedge clk)
    begin : check_response
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
                flag_mismatch("unexpected response beat", 64'(rsp), 64'd0);
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.ok !== want.ok)
                    flag_mismatch("ok", 64'(rsp.ok), 64'(want.ok));
                if (rsp.value_out !== want.value_out)
                    flag_mismatch("value_out", 64'(rsp.value_out), 64'(want.value_out));
                if (rsp.occupancy !== want.occupancy)
                    flag_mismatch("occupancy", 64'(rsp.occupancy), 64'(want.occupancy));
            end
        end
    end

    initial
    begin : stimulus
        logic [KEY_W-1:0] k_ones;
        logic [KEY_W-1:0] k_one;
        logic [KEY_W-1:0] k_top;
        logic [KEY_W-1:0] k_odd;
        logic [KEY_W-1:0] k_even;
        logic [CAP_W-1:0] phase_cap;
        int               phase;
        int               n;
        int               i;

        req_valid   = 1'b0;
        req         = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        steady      = 1'b0;
        beats_taken = 0;
        error_count = 0;
        live_count  = 0;
        capacity    = 5'd16;
        for (i = 0; i < SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_rank[i] = 0;
        end

        k_ones = '1;
        k_one  = 64'd1;
        k_top  = 64'h8000_0000_0000_0000;
        k_odd  = 64'h5555_5555_5555_5555;
        k_even = 64'hAAAA_AAAA_AAAA_AAAA;

        // Directed table. Responses that are obvious by inspection are written out; the
        // rest, where recency order decides, come from the predictor.
        add_capacity(5'd16);
        add_beat(FUNC_LOOKUP, k_one, 32'd0, 1'b1, {1'b0, 32'd0, 5'd0});        // empty cache
        add_beat(FUNC_PEEK, '0, 32'd0, 1'b1, {1'b0, 32'd0, 5'd0});             // empty key
        add_beat(FUNC_STORE, '0, 32'd5, 1'b1, {1'b0, 32'd0, 5'd0});            // refused
        add_beat(FUNC_STORE, k_one, 32'd0, 1'b1, {1'b0, 32'd0, 5'd0});         // refused
        add_beat(FUNC_STORE, k_ones, '1, 1'b1, {1'b1, 32'd0, 5'd1});
        add_beat(FUNC_STORE, k_one, 32'd1, 1'b1, {1'b1, 32'd0, 5'd2});
        add_beat(FUNC_LOOKUP, k_ones, 32'd0, 1'b1, {1'b1, 32'hFFFF_FFFF, 5'd2});
        add_beat(FUNC_PEEK, k_one, 32'd0, 1'b1, {1'b1, 32'd1, 5'd2});
        add_beat(FUNC_STORE, k_one, 32'h8000_0000, 1'b1, {1'b1, 32'd0, 5'd2}); // overwrite
        add_beat(FUNC_LOOKUP, '0, 32'd0, 1'b1, {1'b0, 32'd0, 5'd2});
        add_beat(FUNC_STORE, k_top, 32'h5555_5555);
        add_beat(FUNC_STORE, k_odd, 32'hAAAA_AAAA);
        // Capacity dropped below the occupancy: the surplus only goes at the next new key.
        add_capacity(5'd2);
        add_beat(FUNC_PEEK, k_ones, 32'd0);
        add_beat(FUNC_STORE, k_even, 32'd7);
        add_beat(FUNC_PEEK, k_odd, 32'd0);
        add_beat(FUNC_PEEK, k_top, 32'd0);
        add_beat(FUNC_LOOKUP, k_odd, 32'd0);
        add_beat(FUNC_STORE, k_ones, '1);
        add_beat(FUNC_PEEK, k_even, 32'd0);
        // Zero capacity keeps a single entry.
        add_capacity(5'd0);
        add_beat(FUNC_STORE, k_one, 32'd3);
        add_beat(FUNC_STORE, k_top, 32'd4);
        add_beat(FUNC_PEEK, k_one, 32'd0, 1'b1, {1'b0, 32'd0, 5'd1});
        // The largest register value saturates at the slot count.
        add_capacity(5'd31);
        add_beat(FUNC_CLEAR, k_ones, '1, 1'b1, {1'b1, 32'd0, 5'd0});
        add_beat(FUNC_CLEAR, '0, 32'd0, 1'b1, {1'b1, 32'd0, 5'd0});
        add_beat(FUNC_PEEK, k_top, 32'd0, 1'b1, {1'b0, 32'd0, 5'd0});

        @(posedge rst_n);
        @(posedge clk);
        foreach (script[i])
        begin
            if (script[i].kind == ROW_CAPACITY)
                write_capacity(script[i].cap);
            else
                send_beat(script[i].beat, script[i].typed, script[i].want);
        end

        // Random phases, each under its own capacity and with a fresh pool of keys. One
        // phase runs with no idling at all, and in another the sender waits part-way for
        // every owed response before carrying on.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: phase_cap = 5'd16;
                1: phase_cap = 5'd1;
                2: phase_cap = 5'd31;
                3: phase_cap = 5'd4;
                4: phase_cap = 5'd0;
                5: phase_cap = 5'd16;
                6: phase_cap = 5'd8;
                default: phase_cap = CAP_W'($urandom_range(31));
            endcase
            write_capacity(phase_cap);
            steady = (phase == 5);
            for (i = 0; i < POOL; i++)
            begin
                key_pool[i] = {$urandom, $urandom};
                if (key_pool[i] == '0)
                    key_pool[i] = k_one;
            end
            for (n = 0; n < PHASE_BEATS; n++)
            begin
                if (phase == 1 && n == 40)
                    wait_for_results();
                send_beat(random_beat(), 1'b0, '0);
            end
        end
        steady = 1'b0;

        wait_for_results();
        repeat (6) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_cell.sv
hw/rtl/lru_key_value_cache_top.sv
sim/testbench.sv
